// File: hw/rtl/dew_point_magnus_core_macros.svh
// Assertion macros shared by the dew point core RTL.
// No dependencies; assertions compile out when SYNTH is defined.
`ifndef DEW_POINT_MAGNUS_CORE_MACROS_SVH
`define DEW_POINT_MAGNUS_CORE_MACROS_SVH
`ifndef SYNTH
`define DPM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define DPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define DPM_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define DPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: hw/rtl/dpm_pkg.sv
// Constants and elaboration-time helpers for the Magnus dew point core.
// No dependencies.
package dpm_pkg;

  localparam int TEMP_W = 15;
  localparam int HUM_W  = 14;
  localparam int DEW_W  = 15;

  localparam logic [10:0]        A_NUM     = 11'd1762;
  localparam logic [14:0]        B_NUM     = 15'd24312;
  localparam logic [13:0]        HUM_MIN   = 14'd10;
  localparam logic [13:0]        HUM_MAX   = 14'd10000;
  localparam logic signed [16:0] DEW_MIN   = -17'sd10000;
  localparam logic signed [16:0] DEW_MAX   = 17'sd12500;
  localparam logic [31:0]        LN2_Q32   = 32'd2977044472;
  localparam logic [21:0]        DEW_SCALE = 22'd2431200;

  // Natural log of a constant h in Q(frac), same bit-serial log2 as the datapath
  function automatic logic [63:0] ln_fix_const(input int h, input int frac);
    int          e;
    logic [63:0] m;
    logic [63:0] p;
    e = 0;
    for (int k = 0; k < 31; k++) begin
      if ((h >> (k + 1)) != 0) e = k + 1;
    end
    m = 64'(h) << (30 - e);
    p = 64'(e);
    for (int i = 0; i < frac; i++) begin
      m = (m * m) >> 30;
      p = p << 1;
      if (m >= 64'h8000_0000) begin
        p = p | 64'd1;
        m = m >> 1;
      end
    end
    return (p * 64'(LN2_Q32) + 64'h8000_0000) >> 32;
  endfunction

endpackage

// File: hw/rtl/dpm_ln.sv
// Pipelined natural log: normalize, one squaring step per stage, scale by ln 2.
// Depends on dpm_pkg and the core macro header.
`include "dew_point_magnus_core_macros.svh"
module dpm_ln #(
  parameter int FRAC_BITS = 16,
  parameter int TW        = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [dpm_pkg::HUM_W-1:0]  h,
  input  logic [TW-1:0]              in_tag,
  output logic                       out_valid,
  output logic [FRAC_BITS+3:0]       ln_q,
  output logic [TW-1:0]              out_tag
);
  import dpm_pkg::*;

  localparam int PW = FRAC_BITS + 4;

  logic          vld [0:FRAC_BITS];
  logic [30:0]   m   [0:FRAC_BITS];
  logic [PW-1:0] p   [0:FRAC_BITS];
  logic [TW-1:0] tg  [0:FRAC_BITS];

  logic [3:0]     e;
  logic [30:0]    m_norm;
  logic [PW+31:0] prod;

  // Find the leading one and left-align the mantissa to Q30
  always_comb begin
    e = '0;
    for (int k = 1; k < HUM_W; k++) begin
      if (h[k]) e = 4'(k);
    end
    m_norm = 31'(h) << (5'd30 - 5'(e));
  end

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else vld[0] <= in_valid;
    m[0]  <= m_norm;
    p[0]  <= PW'(e);
    tg[0] <= in_tag;
  end

  // Square the mantissa and emit one fraction bit per stage
  for (genvar s = 0; s < FRAC_BITS; s++) begin : g_sq
    logic [61:0] sq;
    logic [31:0] m2;
    always_comb begin
      sq = 62'(m[s]) * 62'(m[s]);
      m2 = sq[61:30];
    end
    always_ff @(posedge clk) begin
      if (rst) vld[s+1] <= 1'b0;
      else vld[s+1] <= vld[s];
      m[s+1]  <= m2[31] ? m2[31:1] : m2[30:0];
      p[s+1]  <= {p[s][PW-2:0], m2[31]};
      tg[s+1] <= tg[s];
    end
  end

  // Convert log2 to natural log with rounding
  always_comb begin
    prod = (PW+32)'(p[FRAC_BITS]) * (PW+32)'(LN2_Q32) + (PW+32)'(64'h8000_0000);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= vld[FRAC_BITS];
    ln_q    <= prod[PW+31:32];
    out_tag <= tg[FRAC_BITS];
  end

  `DPM_ASSERT_IMP(a_ln_norm, clk, rst, vld[FRAC_BITS], m[FRAC_BITS][30] == 1'b1, "log mantissa lost normalization")

endmodule

// File: hw/rtl/dpm_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on the core macro header; quotient must fit in QW bits.
`include "dew_point_magnus_core_macros.svh"
module dpm_div #(
  parameter int NW = 41,
  parameter int DW = 22,
  parameter int QW = 22,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] in_tag,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [TW-1:0] out_tag
);

  localparam int XW = (NW > DW + QW) ? NW : DW + QW;

  logic          vld [0:QW];
  logic [XW-1:0] rem [0:QW];
  logic [DW-1:0] dd  [0:QW];
  logic [QW-1:0] q   [0:QW];
  logic [TW-1:0] tg  [0:QW];

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else vld[0] <= in_valid;
    rem[0] <= XW'(num);
    dd[0]  <= den;
    q[0]   <= '0;
    tg[0]  <= in_tag;
  end

  // Trial subtract of the shifted divisor, most significant bit first
  for (genvar s = 0; s < QW; s++) begin : g_step
    logic [XW-1:0] trial;
    logic          take;
    always_comb begin
      trial = XW'(dd[s]) << (QW - 1 - s);
      take  = rem[s] >= trial;
    end
    always_ff @(posedge clk) begin
      if (rst) vld[s+1] <= 1'b0;
      else vld[s+1] <= vld[s];
      rem[s+1] <= take ? rem[s] - trial : rem[s];
      dd[s+1]  <= dd[s];
      q[s+1]   <= q[s] | (QW'(take) << (QW - 1 - s));
      tg[s+1]  <= tg[s];
    end
  end

  assign out_valid = vld[QW];
  assign quo       = q[QW];
  assign out_tag   = tg[QW];

  `DPM_ASSERT_IMP(a_div_rem, clk, rst, vld[QW], rem[QW] < XW'(dd[QW]), "divider remainder not below divisor")

endmodule

// File: hw/rtl/dew_point_magnus_core.sv
// Magnus dew point core: clamp, log, ratio divide, gamma, dew divide, saturate.
// Path: input, log pipeline, ratio operands, ratio divider, gamma, dew operands, dew divider
// and output registers; done marks the result, which is taken at the edge that ends done.
// Throughput: one item per cycle; busy is high only during reset.
// The squaring chain of the log and the two bit-serial dividers set the depth.
// Reset (rst, synchronous) clears all valid bits; items in flight are dropped.
`include "dew_point_magnus_core_macros.svh"
module dew_point_magnus_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [dpm_pkg::TEMP_W-1:0] temperature_centi,
  input  logic        [dpm_pkg::HUM_W-1:0]  humidity_centi,
  output logic                              done,
  output logic signed [dpm_pkg::DEW_W-1:0]  dew_point_centi
);
  import dpm_pkg::*;

  localparam int LW   = FRAC_BITS + 4;
  localparam int GW   = FRAC_BITS + 8;
  localparam int NW_R = FRAC_BITS + 25;
  localparam int QW_R = FRAC_BITS + 6;
  localparam int NW_D = FRAC_BITS + 27;
  localparam int DW_D = FRAC_BITS + 13;
  localparam int QW_D = 16;
  localparam logic [63:0] LN_FULL = ln_fix_const(int'(HUM_MAX), FRAC_BITS);

  assign busy = rst;

  // Stage 0: register the item and clamp humidity
  logic                     v0;
  logic signed [TEMP_W-1:0] t0;
  logic [HUM_W-1:0]         h0;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else v0 <= start;
    t0 <= temperature_centi;
    if (humidity_centi < HUM_MIN) h0 <= HUM_MIN;
    else if (humidity_centi > HUM_MAX) h0 <= HUM_MAX;
    else h0 <= humidity_centi;
  end

  // Natural log of humidity, temperature rides along
  logic              lv;
  logic [LW-1:0]     lnv;
  logic [TEMP_W-1:0] lt;

  dpm_ln #(.FRAC_BITS(FRAC_BITS), .TW(TEMP_W)) u_ln (
    .clk(clk), .rst(rst), .in_valid(v0), .h(h0), .in_tag(t0),
    .out_valid(lv), .ln_q(lnv), .out_tag(lt)
  );

  // Stage 1: operands of a*T/(b+T), magnitude plus half divisor for rounding
  logic              t_neg;
  logic [TEMP_W-1:0] t_abs;
  logic [16:0]       bt_sum;
  logic [21:0]       den_r;
  logic [25:0]       at_prod;
  logic [NW_R-1:0]   num_r;
  logic              v1;
  logic [NW_R-1:0]   num_r1;
  logic [21:0]       den_r1;
  logic [LW:0]       tag_r1;

  always_comb begin
    t_neg   = lt[TEMP_W-1];
    t_abs   = t_neg ? TEMP_W'(-lt) : lt;
    bt_sum  = 17'(B_NUM) + {{2{lt[TEMP_W-1]}}, lt};
    den_r   = 22'(22'(bt_sum[15:0]) * 22'd100);
    at_prod = 26'(A_NUM) * 26'(t_abs);
    num_r   = {at_prod[24:0], {FRAC_BITS{1'b0}}} + NW_R'(den_r >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= lv;
    num_r1 <= num_r;
    den_r1 <= den_r;
    tag_r1 <= {t_neg, lnv};
  end

  logic            rv;
  logic [QW_R-1:0] rq;
  logic [LW:0]     rtag;

  dpm_div #(.NW(NW_R), .DW(22), .QW(QW_R), .TW(LW + 1)) u_div_ratio (
    .clk(clk), .rst(rst), .in_valid(v1), .num(num_r1), .den(den_r1), .in_tag(tag_r1),
    .out_valid(rv), .quo(rq), .out_tag(rtag)
  );

  // Stage 2: gamma = ln(hc) - ln(100 %) + ratio
  logic signed [GW-1:0] r_s;
  logic signed [GW-1:0] g_s;
  logic                 v2;
  logic signed [GW-1:0] g2;

  always_comb begin
    r_s = $signed(GW'(rq));
    if (rtag[LW]) r_s = -r_s;
    g_s = $signed(GW'(rtag[LW-1:0])) - $signed(GW'(LN_FULL)) + r_s;
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= rv;
    g2 <= g_s;
  end

  // Stage 3: dew numerator magnitude and divisor a - gamma
  logic [GW-1:0]              g_abs;
  logic [FRAC_BITS+28:0]      dn_prod;
  logic signed [FRAC_BITS+15:0] den_s;
  logic [NW_D-1:0]            num_d;
  logic                       v3;
  logic [NW_D-1:0]            num_d3;
  logic [DW_D-1:0]            den_d3;
  logic [1:0]                 tag_d3;

  always_comb begin
    g_abs   = g2[GW-1] ? GW'(-g2) : GW'(g2);
    dn_prod = (FRAC_BITS+29)'(DEW_SCALE) * (FRAC_BITS+29)'(g_abs[FRAC_BITS+6:0]);
    den_s   = $signed((FRAC_BITS+16)'(A_NUM) << FRAC_BITS)
              - $signed((FRAC_BITS+16)'(7'd100)) * (FRAC_BITS+16)'(g2);
    num_d   = NW_D'(dn_prod) + NW_D'(den_s[DW_D-1:1]);
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    num_d3 <= num_d;
    den_d3 <= den_s[DW_D-1:0];
    tag_d3 <= {g2[GW-1], den_s > 0};
  end

  logic            dv;
  logic [QW_D-1:0] dq;
  logic [1:0]      dtag;

  dpm_div #(.NW(NW_D), .DW(DW_D), .QW(QW_D), .TW(2)) u_div_dew (
    .clk(clk), .rst(rst), .in_valid(v3), .num(num_d3), .den(den_d3), .in_tag(tag_d3),
    .out_valid(dv), .quo(dq), .out_tag(dtag)
  );

  // Stage 4: apply sign, saturate, drive the result
  logic signed [16:0] dew_s;
  logic signed [16:0] dew_sat;

  always_comb begin
    dew_s = $signed(17'(dq));
    if (dtag[1]) dew_s = -dew_s;
    if (!dtag[0]) dew_sat = DEW_MAX;
    else if (dew_s < DEW_MIN) dew_sat = DEW_MIN;
    else if (dew_s > DEW_MAX) dew_sat = DEW_MAX;
    else dew_sat = dew_s;
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= dv;
    dew_point_centi <= dew_sat[DEW_W-1:0];
  end

  `DPM_ASSERT_IMP(a_dew_range, clk, rst, done, (dew_point_centi >= -15'sd10000) && (dew_point_centi <= 15'sd12500), "dew point outside saturation range")
  `DPM_ASSERT_NEXT(a_done_follows, clk, rst, dv, done, "dew divider result not presented")

endmodule

// File: tb/testbench.sv
// Self-checking testbench for dew_point_magnus_core: directed and random items,
// with the expected dew point computed in place. Depends on dpm_pkg and the core RTL.
`timescale 1ns / 100ps
module testbench;
  import dpm_pkg::*;

  localparam int FRAC_BITS  = 16;
  localparam int LATENCY    = 2 * FRAC_BITS + 31;
  localparam int STALL_MAX  = 4000;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic signed [TEMP_W-1:0] temperature_centi;
  logic        [HUM_W-1:0]  humidity_centi;
  logic                     done;
  logic signed [DEW_W-1:0]  dew_point_centi;

  logic signed [DEW_W-1:0] dew_expected_q[$];
  bit   failed = 1'b0;
  int   idle_cycles = 0;
  int   burst_left;

  dew_point_magnus_core #(.FRAC_BITS(FRAC_BITS)) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .temperature_centi(temperature_centi),
    .humidity_centi(humidity_centi),
    .done(done),
    .dew_point_centi(dew_point_centi)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Round to nearest, ties away from zero
  function automatic longint round_div(input longint n, input longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  // Natural log of h in Q(FRAC_BITS) via bit-serial log2 and one ln2 constant
  function automatic longint ln_q(input int h);
    int              e;
    longint unsigned m;
    longint unsigned p;
    e = 0;
    while (e < 31 && (h >> (e + 1)) != 0) e++;
    m = longint'(h) << (30 - e);
    p = longint'(e);
    for (int i = 0; i < FRAC_BITS; i++) begin
      m = (m * m) >> 30;
      p = p << 1;
      if (m >= 64'h8000_0000) begin
        p = p | 64'd1;
        m = m >> 1;
      end
    end
    return longint'((p * 64'(LN2_Q32) + 64'h8000_0000) >> 32);
  endfunction

  function automatic logic signed [DEW_W-1:0] dew_point_of(
      input logic signed [TEMP_W-1:0] t_in, input logic [HUM_W-1:0] h_in);
    longint t;
    int     h;
    longint ratio;
    longint gamma;
    longint den;
    longint dew;
    t = longint'(t_in);
    h = int'(h_in);
    if (h < int'(HUM_MIN)) h = int'(HUM_MIN);
    if (h > int'(HUM_MAX)) h = int'(HUM_MAX);
    ratio = round_div(longint'(A_NUM) * t * (64'sd1 <<< FRAC_BITS),
                      100 * (longint'(B_NUM) + t));
    gamma = ln_q(h) - ln_q(int'(HUM_MAX)) + ratio;
    den = longint'(A_NUM) * (64'sd1 <<< FRAC_BITS) - 100 * gamma;
    if (den <= 0) begin
      dew = longint'(DEW_MAX);
    end else begin
      dew = round_div(longint'(DEW_SCALE) * gamma, den);
      if (dew < longint'(DEW_MIN)) dew = longint'(DEW_MIN);
      if (dew > longint'(DEW_MAX)) dew = longint'(DEW_MAX);
    end
    return DEW_W'(dew);
  endfunction

  // Check each result against the oldest expected dew point
  always @(posedge clk) begin
    if (!rst && done) begin
      if (dew_expected_q.size() == 0) begin
        $error("dew_point_centi: unexpected result %0d", dew_point_centi);
        failed = 1'b1;
      end else begin
        if (dew_point_centi !== dew_expected_q[0]) begin
          $error("dew_point_centi: expected %0d actual %0d",
                 dew_expected_q[0], dew_point_centi);
          failed = 1'b1;
        end
        void'(dew_expected_q.pop_front());
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_MAX) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Present one item and hold it until accepted
  task automatic send_item(input logic signed [TEMP_W-1:0] t,
                           input logic [HUM_W-1:0] h);
    start             <= 1'b1;
    temperature_centi <= t;
    humidity_centi    <= h;
    @(posedge clk);
    while (busy) @(posedge clk);
    dew_expected_q.push_back(dew_point_of(t, h));
  endtask

  // Insert a random gap at the end of each burst
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    gap = $urandom_range(1, 8);
    start <= 1'b0;
    repeat (gap) @(posedge clk);
    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                             : $urandom_range(0, 15);
  endtask

  task automatic test_temperature_extremes();
    logic signed [TEMP_W-1:0] temps[7];
    temps = '{-15'sd16384, 15'sd16383, -15'sd4000, 15'sd12500, 15'sd0, -15'sd1, 15'sd1};
    foreach (temps[i]) begin
      send_item(temps[i], HUM_W'(5000));
      pace();
    end
  endtask

  task automatic test_humidity_clamp();
    logic [HUM_W-1:0] hums[7];
    hums = '{14'd0, 14'd9, 14'd10, 14'd9999, 14'd10000, 14'd10001, 14'd16383};
    foreach (hums[i]) begin
      send_item(15'sd2500, hums[i]);
      pace();
    end
    // Corners of both fields together, driving saturation both ways
    send_item(-15'sd16384, 14'd0);
    send_item(15'sd16383, 14'd16383);
    send_item(-15'sd4000, 14'd10);
    send_item(15'sd12500, 14'd10000);
    pace();
  endtask

  task automatic test_random_typical(input int count);
    repeat (count) begin
      send_item(TEMP_W'($urandom_range(0, 16500) - 4000),
                HUM_W'($urandom_range(0, 10000)));
      pace();
    end
  endtask

  task automatic test_random_full(input int count);
    repeat (count) begin
      send_item(TEMP_W'($urandom()), HUM_W'($urandom()));
      pace();
    end
  endtask

  initial begin
    rst               <= 1'b1;
    start             <= 1'b0;
    temperature_centi <= '0;
    humidity_centi    <= '0;
    burst_left  = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_temperature_extremes();
    test_humidity_clamp();
    test_random_typical(1300);
    test_random_full(400);

    // Drain outstanding results, then watch for strays
    start <= 1'b0;
    while (dew_expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (!failed) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/dpm_pkg.sv
hw/rtl/dpm_ln.sv
hw/rtl/dpm_div.sv
hw/rtl/dew_point_magnus_core.sv
tb/testbench.sv
